// ===== sv/ohlcma_pkg.sv =====
package ohlcma_pkg;

  // Field widths fixed by the interface definition.
  localparam int PRICE_W = 32;
  localparam int SUM_W = 37;
  localparam int CFG_W = 6;
  localparam int CFG_IDX_W = 2;

  // Width of the bit-serial divider step counter.
  localparam int DIV_CNT_W = $clog2(SUM_W);

  // Number of running window sums.
  localparam int NUM_WIN = 3;

  // Tick kinds.
  localparam logic KIND_NEW = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG = 2'd2;

  // Window values after reset.
  localparam logic [CFG_W-1:0] SHORT_RESET = 6'd3;
  localparam logic [CFG_W-1:0] MID_RESET = 6'd5;
  localparam logic [CFG_W-1:0] LONG_RESET = 6'd20;

  typedef logic [PRICE_W-1:0] price_t;
  typedef logic [SUM_W-1:0] sum_t;

endpackage

// ===== sv/ohlcma_in_if.sv =====
interface ohlcma_in_if;
  import ohlcma_pkg::*;

  logic valid;
  logic ready;
  logic kind;
  price_t price;

  modport source (output valid, output kind, output price, input ready);
  modport sink (input valid, input kind, input price, output ready);
endinterface

// ===== sv/ohlcma_out_if.sv =====
interface ohlcma_out_if;
  import ohlcma_pkg::*;

  logic valid;
  logic ready;
  price_t bar_open;
  price_t bar_high;
  price_t bar_low;
  price_t bar_close;
  price_t short_mean;
  price_t mid_mean;
  price_t long_mean;
  logic short_valid;
  logic mid_valid;
  logic long_valid;

  modport source (
    output valid, input ready,
    output bar_open, output bar_high, output bar_low, output bar_close,
    output short_mean, output mid_mean, output long_mean,
    output short_valid, output mid_valid, output long_valid
  );
  modport sink (
    input valid, output ready,
    input bar_open, input bar_high, input bar_low, input bar_close,
    input short_mean, input mid_mean, input long_mean,
    input short_valid, input mid_valid, input long_valid
  );
endinterface

// ===== sv/ohlc_bar_moving_average.sv =====
// Channel   Direction  Handshake              Contents
// in_chan   in         valid/ready            kind, price (Q16.16)
// out_chan  out        valid/ready            OHLC of current bar, three means, flags
// cfg_*     in         cfg_we, no back-pressure  short/mid/long window registers
//
// A new word is accepted only once the last one is done. The bit-serial
// divider runs 37 steps for each of the three means, after the close-ring
// reads and sum updates. The reset is synchronous and active low; the close
// ring has no reset and needs no clearing pass. A result that waits in the
// output register does not block the next word; only the word after that
// waits until the result is taken.
module ohlc_bar_moving_average #(
  parameter int MAX_WINDOW = 32
) (
  input  logic clk,
  input  logic rst_n,
  ohlcma_in_if.sink in_chan,
  ohlcma_out_if.source out_chan,
  input  logic cfg_we,
  input  logic [ohlcma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ohlcma_pkg::CFG_W-1:0] cfg_data
);
  import ohlcma_pkg::*;

  // Ring pointer width, and width of a window or bar count (0..MAX_WINDOW).
  localparam int AW = $clog2(MAX_WINDOW);
  localparam int WW = $clog2(MAX_WINDOW + 1);
  localparam int SW = WW + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD = 3'd1;
  localparam logic [2:0] ST_ACC = 3'd2;
  localparam logic [2:0] ST_WR = 3'd3;
  localparam logic [2:0] ST_LD = 3'd4;
  localparam logic [2:0] ST_DIV = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  localparam logic [1:0] LAST_WIN = 2'(NUM_WIN - 1);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

  // A zero window counts as one and a window beyond the ring is clamped.
  function automatic logic [WW-1:0] eff_win(input logic [CFG_W-1:0] r);
    logic [WW-1:0] w;
    if (r == '0) begin
      w = WW'(1);
    end else if (32'(r) > MAX_WINDOW) begin
      w = WW'(MAX_WINDOW);
    end else begin
      w = WW'(r);
    end
    return w;
  endfunction

  // Ring slot k places before the write pointer, k in 1..MAX_WINDOW.
  function automatic logic [AW-1:0] slot_back(input logic [AW-1:0] wp,
                                              input logic [WW-1:0] k);
    logic [SW-1:0] d;
    d = SW'(wp) - SW'(k);
    if (SW'(wp) < SW'(k)) begin
      d = d + SW'(MAX_WINDOW);
    end
    return d[AW-1:0];
  endfunction

  // Quotients beyond 32 bits appear only after a window change; they clip.
  function automatic price_t sat_mean(input sum_t q);
    price_t m;
    if (q[SUM_W-1:PRICE_W] != '0) begin
      m = '1;
    end else begin
      m = q[PRICE_W-1:0];
    end
    return m;
  endfunction

  logic [2:0] state_r, state_nxt;
  logic [1:0] j_r, j_nxt;
  logic [DIV_CNT_W-1:0] bit_r, bit_nxt;
  logic new_bar_r, new_bar_nxt;
  price_t price_r, price_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [WW-1:0] cnt_r, cnt_nxt;
  sum_t sum_r [NUM_WIN];
  sum_t sum_nxt [NUM_WIN];
  logic [CFG_W-1:0] cfg_win_r [NUM_WIN];
  logic [CFG_W-1:0] cfg_win_nxt [NUM_WIN];
  price_t mean_r [NUM_WIN];
  price_t mean_nxt [NUM_WIN];
  logic flag_r [NUM_WIN];
  logic flag_nxt [NUM_WIN];
  price_t open_r, open_nxt;
  price_t high_r, high_nxt;
  price_t low_r, low_nxt;
  price_t close_r, close_nxt;
  sum_t dq_r, dq_nxt;
  logic [WW-1:0] rem_r, rem_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_load;

  price_t rdata_r;
  price_t mem [MAX_WINDOW];
  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] rd_addr;

  logic [WW-1:0] win [NUM_WIN];
  logic [WW-1:0] cur_win;
  logic [WW-1:0] cnt_inc;
  logic drop;
  logic [SW-1:0] rem_sh;
  logic rem_ge;
  sum_t dq_step;
  logic [WW-1:0] rem_step;

  price_t out_open_r, out_high_r, out_low_r, out_close_r;
  price_t out_mean_r [NUM_WIN];
  logic out_flag_r [NUM_WIN];

  always_comb begin
    for (int i = 0; i < NUM_WIN; i++) begin
      win[i] = eff_win(cfg_win_r[i]);
    end
  end

  assign cur_win = win[j_r];
  assign in_chan.ready = (state_r == ST_IDLE);
  assign cnt_inc = (32'(cnt_r) < MAX_WINDOW) ? cnt_r + WW'(1) : cnt_r;

  // A new bar reads the close leaving each window; an update reads the newest
  // close, which it always takes back out of every sum.
  assign rd_addr = slot_back(wp_r, new_bar_r ? cur_win : WW'(1));
  assign drop = new_bar_r ? (cnt_r >= cur_win) : 1'b1;
  assign mem_we = (state_r == ST_WR);
  assign mem_waddr = new_bar_r ? wp_r : slot_back(wp_r, WW'(1));

  // One restoring-division step: bring in the next dividend bit from the top.
  assign rem_sh = {rem_r, dq_r[SUM_W-1]};
  assign rem_ge = (rem_sh >= SW'(cur_win));
  assign rem_step = rem_ge ? WW'(rem_sh - SW'(cur_win)) : rem_sh[WW-1:0];
  assign dq_step = {dq_r[SUM_W-2:0], rem_ge};

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    j_nxt = j_r;
    bit_nxt = bit_r;
    new_bar_nxt = new_bar_r;
    price_nxt = price_r;
    wp_nxt = wp_r;
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    cfg_win_nxt = cfg_win_r;
    mean_nxt = mean_r;
    flag_nxt = flag_r;
    open_nxt = open_r;
    high_nxt = high_r;
    low_nxt = low_r;
    close_nxt = close_r;
    dq_nxt = dq_r;
    rem_nxt = rem_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;

    if (cfg_we) begin
      case (cfg_index)
        CFG_SHORT: cfg_win_nxt[0] = cfg_data;
        CFG_MID: cfg_win_nxt[1] = cfg_data;
        CFG_LONG: cfg_win_nxt[2] = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          price_nxt = in_chan.price;
          new_bar_nxt = (in_chan.kind == KIND_NEW) || (cnt_r == '0);
          j_nxt = '0;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        sum_nxt[j_r] = sum_r[j_r] + SUM_W'(price_r);
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (drop) begin
          sum_nxt[j_r] = sum_r[j_r] - SUM_W'(rdata_r);
        end
        if (j_r == LAST_WIN) begin
          state_nxt = ST_WR;
        end else begin
          j_nxt = j_r + 2'd1;
          state_nxt = ST_RD;
        end
      end
      ST_WR: begin
        close_nxt = price_r;
        if (new_bar_r) begin
          wp_nxt = (wp_r == AW'(MAX_WINDOW - 1)) ? '0 : wp_r + AW'(1);
          cnt_nxt = cnt_inc;
          open_nxt = price_r;
          high_nxt = price_r;
          low_nxt = price_r;
        end else begin
          if (price_r > high_r) begin
            high_nxt = price_r;
          end
          if (price_r < low_r) begin
            low_nxt = price_r;
          end
        end
        for (int i = 0; i < NUM_WIN; i++) begin
          flag_nxt[i] = new_bar_r && (cnt_inc >= win[i]);
        end
        j_nxt = '0;
        state_nxt = ST_LD;
      end
      ST_LD: begin
        dq_nxt = sum_r[j_r];
        rem_nxt = '0;
        bit_nxt = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        dq_nxt = dq_step;
        rem_nxt = rem_step;
        bit_nxt = bit_r + DIV_CNT_W'(1);
        if (bit_r == DIV_LAST) begin
          mean_nxt[j_r] = sat_mean(dq_step);
          if (j_r == LAST_WIN) begin
            state_nxt = ST_DONE;
          end else begin
            j_nxt = j_r + 2'd1;
            state_nxt = ST_LD;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      j_r <= '0;
      bit_r <= '0;
      wp_r <= '0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      cfg_win_r[0] <= SHORT_RESET;
      cfg_win_r[1] <= MID_RESET;
      cfg_win_r[2] <= LONG_RESET;
      for (int i = 0; i < NUM_WIN; i++) begin
        sum_r[i] <= '0;
      end
      open_r <= '0;
      high_r <= '0;
      low_r <= '0;
      close_r <= '0;
    end else begin
      state_r <= state_nxt;
      j_r <= j_nxt;
      bit_r <= bit_nxt;
      wp_r <= wp_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_win_r <= cfg_win_nxt;
      sum_r <= sum_nxt;
      open_r <= open_nxt;
      high_r <= high_nxt;
      low_r <= low_nxt;
      close_r <= close_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_bar_r <= new_bar_nxt;
    price_r <= price_nxt;
    mean_r <= mean_nxt;
    flag_r <= flag_nxt;
    dq_r <= dq_nxt;
    rem_r <= rem_nxt;
    if (out_load) begin
      out_open_r <= open_r;
      out_high_r <= high_r;
      out_low_r <= low_r;
      out_close_r <= close_r;
      out_mean_r <= mean_r;
      out_flag_r <= flag_r;
    end
  end

  // Close ring: leaving closes are read before the new close is written.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= price_r;
    end
    if (state_r == ST_RD) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.bar_open = out_open_r;
  assign out_chan.bar_high = out_high_r;
  assign out_chan.bar_low = out_low_r;
  assign out_chan.bar_close = out_close_r;
  assign out_chan.short_mean = out_mean_r[0];
  assign out_chan.mid_mean = out_mean_r[1];
  assign out_chan.long_mean = out_mean_r[2];
  assign out_chan.short_valid = out_flag_r[0];
  assign out_chan.mid_valid = out_flag_r[1];
  assign out_chan.long_valid = out_flag_r[2];

endmodule
